### hdl/mip_chain_box_downsampler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mip chain box downsampler
// Clocked on clk; MCBD_ASSERT is disabled while arst_n is low, MCBD_ASSERT_ALWAYS is not.
// ----------------------------------------------------------------------------
`ifndef MIP_CHAIN_BOX_DOWNSAMPLER_ASSERT_SVH
`define MIP_CHAIN_BOX_DOWNSAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define MCBD_ASSERT(lbl, prop, msg) lbl: assert property (@(posedge clk) \
	disable iff (!arst_n) prop) else $error(msg);
`define MCBD_ASSERT_ALWAYS(lbl, prop, msg) lbl: assert property (@(posedge clk) \
	prop) else $error(msg);
`else
`define MCBD_ASSERT(lbl, prop, msg)
`define MCBD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### hdl/mcbd_pkg.sv
// ----------------------------------------------------------------------------
// mcbd_pkg
// Shared constants, types and helpers of the mip chain box downsampler.
// ----------------------------------------------------------------------------
`default_nettype none
package mcbd_pkg;
	localparam int MAX_DIM   = 4096;
	localparam int DIM_W     = 13;
	localparam int ADDR_W    = 12;
	localparam int LEVELS    = 12;
	localparam int LVL_W     = 4;
	localparam int POS_W     = 12;
	localparam int XY_W      = 11;
	localparam int CHANNELS  = 4;
	localparam int SUM_W     = 9;
	localparam int LINE_W    = CHANNELS * SUM_W;
	localparam int IDX_W     = 2;
	localparam int CNT_W     = 3;
	localparam int OUT_W     = 64;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH    = 2'd0,
		REG_HEIGHT   = 2'd1,
		REG_CHANNELS = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_RDWAIT,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic finish;
		logic flush;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic stop;
		logic need_read;
		logic hold_valid;
		logic out_free;
	} dp_stat_t;

	typedef struct packed {
		logic [LVL_W-1:0]          lvl;
		logic [XY_W-1:0]           x;
		logic [XY_W-1:0]           y;
		logic [CHANNELS-1:0][7:0]  chan;
	} res_t;

	// Map a written size onto 1..MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
		else r = v;
		return r;
	endfunction
endpackage
`default_nettype wire

### hdl/mcbd_ram.sv
// ----------------------------------------------------------------------------
// mcbd_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mcbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write or read one entry per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule
`default_nettype wire

### hdl/mcbd_ctrl.sv
// ----------------------------------------------------------------------------
// mcbd_ctrl
// Sequencer: walks one input pixel up the level chain, one level per step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mip_chain_box_downsampler_assert.svh"
module mcbd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire mcbd_pkg::dp_stat_t stat,
	output      mcbd_pkg::dp_cmd_t  cmd
);
	import mcbd_pkg::*;

	state_t state_q, state_d;
	logic   can_push;

	assign can_push = !stat.hold_valid || stat.out_free;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_LEVEL;
			end
			ST_LEVEL: begin
				if (!stat.active) state_d = ST_FLUSH;
				else if (can_push) begin
					if (stat.need_read) state_d = ST_RDWAIT;
					else if (stat.stop) state_d = ST_FLUSH;
				end
			end
			ST_RDWAIT: begin
				if (can_push) state_d = ST_LEVEL;
			end
			ST_FLUSH: begin
				if (can_push) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		cmd.accept = (state_q == ST_IDLE) && s_tvalid;
		cmd.step   = (state_q == ST_LEVEL) && stat.active && can_push;
		cmd.finish = (state_q == ST_RDWAIT) && can_push;
		cmd.flush  = (state_q == ST_FLUSH) && stat.hold_valid && stat.out_free;
	end

	`MCBD_ASSERT(a_step_active, cmd.step |-> stat.active, "step on inactive level")
	`MCBD_ASSERT(a_rdwait_entry, (state_q == ST_RDWAIT) |-> ($past(state_q) == ST_LEVEL || $past(state_q) == ST_RDWAIT), "bad entry to read wait")
	`MCBD_ASSERT(a_flush_clears, cmd.flush |=> !stat.hold_valid, "held result not drained")
	`MCBD_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.accept, cmd.step, cmd.finish, cmd.flush}), "commands overlap")
endmodule
`default_nettype wire

### hdl/mcbd_dp.sv
// ----------------------------------------------------------------------------
// mcbd_dp
// Datapath: configuration, per-level positions, pair sums, line store and
// result holding.
// ----------------------------------------------------------------------------
`default_nettype none
module mcbd_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	input  wire logic [mcbd_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [mcbd_pkg::DIM_W-1:0]         cfg_data,
	input  wire logic [mcbd_pkg::CHANNELS-1:0][7:0] pix_in,
	input  wire mcbd_pkg::dp_cmd_t                  cmd,
	output      mcbd_pkg::dp_stat_t                 stat,
	output      logic                               m_tvalid,
	input  wire logic                               m_tready,
	output      mcbd_pkg::res_t                     m_res,
	output      logic                               m_tlast
);
	import mcbd_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [CNT_W-1:0] chans_q;
	logic [DIM_W-1:0] sw0, sh0;
	logic [CNT_W-1:0] chn;

	logic [CHANNELS-1:0][7:0] pix_q;
	logic [LVL_W-1:0]         lvl_q;
	logic [DIM_W-1:0]         off_q, sw_q, sh_q;
	logic [POS_W-1:0]         col_q [LEVELS];
	logic [POS_W-1:0]         row_q [LEVELS];
	logic [CHANNELS-1:0][7:0] pend_q [LEVELS];

	logic [XY_W-1:0]               x_q, y_q;
	logic [CHANNELS-1:0][SUM_W-1:0] hs_q;
	logic [1:0]                    shf_q;
	logic                          idx_ok_q;

	res_t h_q;
	logic h_valid_q;
	logic ov_q, olast_q;
	res_t o_q;

	logic [LVL_W-1:0] li;
	logic [POS_W-1:0] c, r;
	logic [DIM_W-1:0] c_next, r_next, idx, dw, dh;
	logic [CHANNELS-1:0][7:0] pend;
	logic [CHANNELS-1:0][SUM_W-1:0] hs;
	logic [XY_W-1:0] x, y;
	logic h_one, v_one, hstop, vstop, need_read, produce, idx_ok, out_free;
	logic ram_we, ram_re;
	logic [LINE_W-1:0] ram_rd;
	res_t res;

	// Clamp configuration
	always_comb begin
		sw0 = clamp_dim(width_q);
		sh0 = clamp_dim(height_q);
		if (chans_q == '0) chn = CNT_W'(1);
		else if (chans_q > CNT_W'(CHANNELS)) chn = CNT_W'(CHANNELS);
		else chn = chans_q;
	end

	// Evaluate current level
	always_comb begin
		li     = lvl_q - LVL_W'(1);
		c      = col_q[li];
		r      = row_q[li];
		pend   = pend_q[li];
		c_next = DIM_W'(c) + DIM_W'(1);
		r_next = DIM_W'(r) + DIM_W'(1);
		h_one  = (sw_q == DIM_W'(1));
		v_one  = (sh_q == DIM_W'(1));
		for (int k = 0; k < CHANNELS; k++) begin
			hs[k] = h_one ? SUM_W'(pix_q[k]) : SUM_W'(pend[k]) + SUM_W'(pix_q[k]);
		end
		hstop     = !h_one && !c[0];
		vstop     = !v_one && !r[0];
		need_read = !hstop && !v_one && r[0];
		x         = h_one ? '0 : c[POS_W-1:1];
		y         = v_one ? '0 : r[POS_W-1:1];
		idx       = off_q + DIM_W'(x);
		idx_ok    = (idx < DIM_W'(MAX_DIM));
		dw        = (sw_q[DIM_W-1:1] == '0) ? DIM_W'(1) : DIM_W'(sw_q[DIM_W-1:1]);
		dh        = (sh_q[DIM_W-1:1] == '0) ? DIM_W'(1) : DIM_W'(sh_q[DIM_W-1:1]);
	end

	// Status to the sequencer
	assign out_free        = !ov_q || m_tready;
	assign stat.active     = (sw_q > DIM_W'(1) || sh_q > DIM_W'(1)) && (lvl_q <= LVL_W'(LEVELS));
	assign stat.stop       = hstop || vstop;
	assign stat.need_read  = need_read;
	assign stat.hold_valid = h_valid_q;
	assign stat.out_free   = out_free;

	// Line store of upper-row pair sums
	assign ram_we = cmd.step && !hstop && vstop && (r_next < sh_q) && idx_ok;
	assign ram_re = cmd.step && need_read;

	mcbd_ram #(.WIDTH(LINE_W), .DEPTH(MAX_DIM)) u_line (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (idx[ADDR_W-1:0]),
		.wdata (hs),
		.rdata (ram_rd)
	);

	// Form the averaged result
	always_comb begin
		logic [SUM_W:0] tot;
		logic [SUM_W-1:0] above;
		produce = (cmd.step && !hstop && !vstop && !need_read) || cmd.finish;
		res.lvl = lvl_q;
		res.x   = cmd.finish ? x_q : x;
		res.y   = cmd.finish ? y_q : y;
		for (int k = 0; k < CHANNELS; k++) begin
			above = idx_ok_q ? ram_rd[k*SUM_W +: SUM_W] : '0;
			if (cmd.finish) begin
				tot = (SUM_W+1)'(above) + (SUM_W+1)'(hs_q[k]);
				res.chan[k] = 8'(tot >> shf_q);
			end else begin
				tot = (SUM_W+1)'(hs[k]);
				res.chan[k] = 8'(tot >> (h_one ? 0 : 1));
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			chans_q  <= CNT_W'(CHANNELS);
		end else if (cfg_valid) begin
			if (cfg_index == REG_WIDTH) width_q <= cfg_data;
			if (cfg_index == REG_HEIGHT) height_q <= cfg_data;
			if (cfg_index == REG_CHANNELS) chans_q <= cfg_data[CNT_W-1:0];
		end
	end

	// Per-level positions and pending left pixels; restart on any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				col_q[i]  <= '0;
				row_q[i]  <= '0;
				pend_q[i] <= '0;
			end
		end else if (cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
				cfg_index == REG_CHANNELS)) begin
			for (int i = 0; i < LEVELS; i++) begin
				col_q[i]  <= '0;
				row_q[i]  <= '0;
				pend_q[i] <= '0;
			end
		end else if (cmd.step) begin
			if (c_next >= sw_q) begin
				col_q[li] <= '0;
				row_q[li] <= (r_next >= sh_q) ? '0 : r_next[POS_W-1:0];
			end else begin
				col_q[li] <= c_next[POS_W-1:0];
			end
			if (hstop && c_next < sw_q) pend_q[li] <= pix_q;
		end
	end

	// Walk state of the current pixel
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			for (int k = 0; k < CHANNELS; k++) begin
				pix_q[k] <= (CNT_W'(k) < chn) ? pix_in[k] : 8'd0;
			end
			lvl_q <= LVL_W'(1);
			off_q <= '0;
			sw_q  <= sw0;
			sh_q  <= sh0;
		end else if (produce) begin
			pix_q <= res.chan;
			lvl_q <= lvl_q + LVL_W'(1);
			off_q <= off_q + dw;
			sw_q  <= dw;
			sh_q  <= dh;
		end
		if (ram_re) begin
			x_q      <= x;
			y_q      <= y;
			hs_q     <= hs;
			shf_q    <= h_one ? 2'd1 : 2'd2;
			idx_ok_q <= idx_ok;
		end
	end

	// Hold the newest result until the next one shows whether it is last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_valid_q <= 1'b0;
			ov_q      <= 1'b0;
			olast_q   <= 1'b0;
		end else begin
			if (m_tready) ov_q <= 1'b0;
			if (produce) begin
				h_valid_q <= 1'b1;
				if (h_valid_q) begin
					ov_q    <= 1'b1;
					olast_q <= 1'b0;
				end
			end else if (cmd.flush) begin
				h_valid_q <= 1'b0;
				ov_q      <= 1'b1;
				olast_q   <= 1'b1;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (produce) begin
			h_q <= res;
			if (h_valid_q) o_q <= h_q;
		end else if (cmd.flush) begin
			o_q <= h_q;
		end
	end

	assign m_tvalid = ov_q;
	assign m_res    = o_q;
	assign m_tlast  = olast_q;
endmodule
`default_nettype wire

### hdl/mip_chain_box_downsampler.sv
// ----------------------------------------------------------------------------
// mip_chain_box_downsampler
// Streams level-0 pixels in and emits every finished pixel of the mip chain.
// ----------------------------------------------------------------------------
// channel  direction  width  content
// s_*      in         32     level-0 pixel, chan0..chan3
// m_*      out        64     produced pixel, tlast on last of a transaction
// cfg_*    in         2+13   register index and value
//
// An input is taken while idle; the walk then steps one level at a time,
// waits on each level that reads the line store (single-port RAM, registered
// read), and ends in a flush state that releases the held result.
// A result leaves through a one-deep hold stage and an output register; a
// stalled output stops the level walk.
// Reset clears positions and control; the line store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module mip_chain_box_downsampler (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output      logic                           s_tready,
	// chan0_in[7:0], chan1_in[15:8], chan2_in[23:16], chan3_in[31:24]
	input  wire logic [31:0]                    s_tdata,
	output      logic                           m_tvalid,
	input  wire logic                           m_tready,
	// mip_level[3:0], pos_x[14:4], pos_y[25:15], chan0_out[33:26],
	// chan1_out[41:34], chan2_out[49:42], chan3_out[57:50], zero[63:58]
	output      logic [mcbd_pkg::OUT_W-1:0]     m_tdata,
	output      logic                           m_tlast,
	input  wire logic                           cfg_valid,
	output      logic                           cfg_ready,
	input  wire logic [mcbd_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [mcbd_pkg::DIM_W-1:0]     cfg_data
);
	import mcbd_pkg::*;

	dp_cmd_t                  cmd;
	dp_stat_t                 stat;
	res_t                     res;
	logic [CHANNELS-1:0][7:0] pix;

	assign cfg_ready = 1'b1;
	assign pix       = s_tdata;

	mcbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mcbd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (pix),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_res     (res),
		.m_tlast   (m_tlast)
	);

	// Pack result fields, level lowest
	assign m_tdata = {6'd0, res.chan[3], res.chan[2], res.chan[1], res.chan[0],
			res.y, res.x, res.lvl};
endmodule
`default_nettype wire

### bench/mip_chain_box_downsampler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mip_chain_box_downsampler_checker
// Watches the register, pixel and result channels of the mip chain box
// downsampler. Every accepted level-0 pixel is run through a cycle-free
// cascade of 2x2 box filters that predicts the downsampled pixels it
// completes. Every accepted result is compared field by field with the
// oldest predicted pixel.
// ----------------------------------------------------------------------------
module mip_chain_box_downsampler_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [31:0]                    s_tdata,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [mcbd_pkg::OUT_W-1:0]     m_tdata,
	input  logic                           m_tlast,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [mcbd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [mcbd_pkg::DIM_W-1:0]     cfg_data,
	output int                             mismatch_count,
	output int                             pixels_owed
);
	import mcbd_pkg::*;

	typedef struct {
		int lvl;
		int x;
		int y;
		int chan[4];
		bit last;
	} mip_pixel_t;

	mip_pixel_t owed_pixels[$];

	// Filter configuration and per-level cascade state
	logic [DIM_W-1:0] img_w;
	logic [DIM_W-1:0] img_h;
	logic [CNT_W-1:0] chan_cnt;
	int               src_col[1:LEVELS];
	int               src_row[1:LEVELS];
	int               left_pix[1:LEVELS][4];
	logic [LINE_W-1:0] pair_sums[0:MAX_DIM-1];

	assign pixels_owed = owed_pixels.size();

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic restart_frame();
		for (int l = 1; l <= LEVELS; l++) begin
			src_col[l] = 0;
			src_row[l] = 0;
			for (int k = 0; k < 4; k++) left_pix[l][k] = 0;
		end
	endtask

	// Push one level-0 pixel through the cascade, queue every finished pixel
	task automatic downsample_pixel(input logic [31:0] pix);
		int sw, sh, ch, levels, m, off, c, r, dw, dh, hcnt, shift, x, y, idx, n;
		int p[4];
		int hs[4];
		int tot[4];
		logic [LINE_W-1:0] w;
		bit stopped;
		mip_pixel_t res;
		sw = (img_w == 0) ? 1 : ((img_w > MAX_DIM) ? MAX_DIM : int'(img_w));
		sh = (img_h == 0) ? 1 : ((img_h > MAX_DIM) ? MAX_DIM : int'(img_h));
		ch = (chan_cnt == 0) ? 1 : ((chan_cnt > CHANNELS) ? CHANNELS : int'(chan_cnt));
		for (int k = 0; k < 4; k++) p[k] = (k < ch) ? int'(pix[8*k +: 8]) : 0;
		levels = 1;
		m = (sw > sh) ? sw : sh;
		while (m > 1) begin
			m = m >> 1;
			levels++;
		end
		off = 0;
		n = 0;
		stopped = 0;
		for (int lvl = 1; lvl < levels && !stopped; lvl++) begin
			dw = (sw / 2 == 0) ? 1 : sw / 2;
			dh = (sh / 2 == 0) ? 1 : sh / 2;
			c = src_col[lvl];
			r = src_row[lvl];
			// advance the source position of this level, wrap at frame end
			if (c + 1 >= sw) begin
				src_col[lvl] = 0;
				src_row[lvl] = (r + 1 >= sh) ? 0 : r + 1;
			end else begin
				src_col[lvl] = c + 1;
			end
			// horizontal pair
			if (sw == 1) begin
				hs = p;
				hcnt = 1;
			end else if (c % 2 == 0) begin
				if (c + 1 < sw) left_pix[lvl] = p;
				stopped = 1;
			end else begin
				for (int k = 0; k < 4; k++) hs[k] = left_pix[lvl][k] + p[k];
				hcnt = 2;
			end
			if (!stopped) begin
				x = (sw == 1) ? 0 : c / 2;
				idx = off + x;
				// vertical pair through the line store
				if (sh == 1) begin
					tot = hs;
					shift = hcnt - 1;
				end else if (r % 2 == 0) begin
					if (r + 1 < sh && idx < MAX_DIM) begin
						for (int k = 0; k < 4; k++) w[SUM_W*k +: SUM_W] = hs[k][SUM_W-1:0];
						pair_sums[idx] = w;
					end
					stopped = 1;
				end else begin
					w = (idx < MAX_DIM) ? pair_sums[idx] : '0;
					for (int k = 0; k < 4; k++) tot[k] = int'(w[SUM_W*k +: SUM_W]) + hs[k];
					shift = hcnt;
				end
			end
			if (!stopped) begin
				y = (sh == 1) ? 0 : r / 2;
				for (int k = 0; k < 4; k++) p[k] = (tot[k] >> shift) & 8'hFF;
				res.lvl = lvl;
				res.x = x;
				res.y = y;
				res.chan = p;
				res.last = 0;
				owed_pixels = {owed_pixels, res};
				n++;
				off += dw;
				sw = dw;
				sh = dh;
			end
		end
		if (n > 0) owed_pixels[owed_pixels.size() - 1].last = 1;
	endtask

	// Track register writes, predict on pixels, compare on results
	always @(posedge clk or negedge arst_n) begin
		mip_pixel_t want;
		if (!arst_n) begin
			img_w = 1;
			img_h = 1;
			chan_cnt = 4;
			restart_frame();
			owed_pixels.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH: begin
						img_w = cfg_data;
						restart_frame();
					end
					REG_HEIGHT: begin
						img_h = cfg_data;
						restart_frame();
					end
					REG_CHANNELS: begin
						chan_cnt = cfg_data[CNT_W-1:0];
						restart_frame();
					end
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) downsample_pixel(s_tdata);
			if (m_tvalid && m_tready) begin
				if (owed_pixels.size() == 0) begin
					report_mismatch("unexpected result, level", int'(m_tdata[3:0]), 0);
				end else begin
					want = owed_pixels.pop_front();
					if (m_tdata[3:0] != want.lvl)
						report_mismatch("mip_level", int'(m_tdata[3:0]), want.lvl);
					if (m_tdata[14:4] != want.x)
						report_mismatch("pos_x", int'(m_tdata[14:4]), want.x);
					if (m_tdata[25:15] != want.y)
						report_mismatch("pos_y", int'(m_tdata[25:15]), want.y);
					for (int k = 0; k < 4; k++) begin
						if (m_tdata[26 + 8*k +: 8] != want.chan[k])
							report_mismatch($sformatf("chan%0d_out", k),
								int'(m_tdata[26 + 8*k +: 8]), want.chan[k]);
					end
					if (m_tdata[63:58] != 0)
						report_mismatch("padding", int'(m_tdata[63:58]), 0);
					if (m_tlast != want.last)
						report_mismatch("run_last", int'(m_tlast), int'(want.last));
				end
			end
		end
	end
endmodule

### bench/tb_mip_chain_box_downsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mip_chain_box_downsampler
// Drives level-0 pixels through several image sizes and channel counts:
// a directed 4x4 frame, zero, single-column, oversized and random sizes,
// with random gaps on both channels and one long output stall. The checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_mip_chain_box_downsampler;
	import mcbd_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [31:0]          s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	int                   mismatch_count;
	int                   pixels_owed;
	int                   pixels_taken;
	int                   stall_cycles;
	bit                   stall_done;
	bit                   calm;

	mip_chain_box_downsampler dut (.*);

	mip_chain_box_downsampler_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("mip_chain_box_downsampler: mismatch");
		$finish;
	end

	// Count accepted pixels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_taken <= 0;
		end else if (s_tvalid && s_tready) begin
			pixels_taken <= pixels_taken + 1;
		end
	end

	// Result side: random back-pressure and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			stall_cycles <= 0;
			stall_done <= 0;
		end else if (!stall_done && pixels_taken >= 10) begin
			m_tready <= 0;
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == 400) stall_done <= 1;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 18);
		end
	end

	task automatic send_pixel(input logic [31:0] pix);
		if (!calm && $urandom_range(99) < 18) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Drain all results and any silent work, then load a new image setup
	task automatic setup_image(input int w, input int h, input int ch);
		s_tvalid <= 0;
		while (pixels_owed != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		write_reg(REG_WIDTH, DIM_W'(w));
		write_reg(REG_HEIGHT, DIM_W'(h));
		write_reg(REG_CHANNELS, DIM_W'(ch));
		cfg_valid <= 0;
	endtask

	initial begin
		int sent;
		int n;
		logic [31:0] pix;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_valid = 0;
		cfg_index = REG_WIDTH;
		cfg_data = 0;
		calm = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// 4x4 frame of extremes, then the start of a wrapped frame
		setup_image(4, 4, 4);
		for (int i = 0; i < 20; i++) begin
			pix = i[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
			if (i >= 8) pix = pix ^ 32'h00FF_00FF;
			send_pixel(pix);
		end

		// zero sizes and zero channels: a single level, no results
		setup_image(0, 0, 0);
		for (int i = 0; i < 5; i++) send_pixel($urandom);

		// single column, oversized channel count
		setup_image(1, 8, 7);
		for (int i = 0; i < 16; i++) send_pixel($urandom);

		// oversized single row, no gaps
		calm = 1;
		setup_image(8191, 1, 1);
		for (int i = 0; i < 80; i++) send_pixel($urandom);
		calm = 0;

		// random small images, an occasional larger one
		sent = 0;
		while (sent < 100) begin
			if ($urandom_range(99) < 10)
				setup_image($urandom_range(13, 64), $urandom_range(1, 12), $urandom_range(0, 7));
			else
				setup_image($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(0, 7));
			n = $urandom_range(4, 40);
			for (int i = 0; i < n; i++) send_pixel($urandom);
			sent += n;
		end
		s_tvalid <= 0;

		while (pixels_owed != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("mip_chain_box_downsampler: match");
		end else begin
			$display("mip_chain_box_downsampler: mismatch");
		end
		$finish;
	end
endmodule

### filelist.f
+incdir+hdl
hdl/mcbd_pkg.sv
hdl/mcbd_ram.sv
hdl/mcbd_ctrl.sv
hdl/mcbd_dp.sv
hdl/mip_chain_box_downsampler.sv
bench/mip_chain_box_downsampler_checker.sv
bench/tb_mip_chain_box_downsampler.sv
